// File: sv/row_gap_fill_detector_assert.svh
// Assertion macros for the row gap fill detector.
`ifndef ROW_GAP_FILL_DETECTOR_ASSERT_SVH
`define ROW_GAP_FILL_DETECTOR_ASSERT_SVH
// Property that must hold on every clock edge outside reset.
`define RGFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// When cond holds at one edge, nxt must hold at the next edge; checked outside reset.
`define RGFD_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> nxt) \
        else $error(msg);
`endif

// File: sv/rgfd_pkg.sv
// Package with constants and types for the row gap fill detector.
package rgfd_pkg;
    localparam int MaxCols = 1024;
    localparam int MaxRows = 4096;
    localparam int ColW = $clog2(MaxCols);
    localparam int RowW = $clog2(MaxRows);
    localparam logic [1:0] RegEdgeTol = 2'd0;
    localparam logic [1:0] RegRefTol = 2'd1;
    localparam logic [1:0] RegSamples = 2'd2;
    localparam logic [8:0] BgLevel = 9'd128;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BSET = 7'b0000010,
        S_IDX  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_CMP  = 7'b1000000
    } t_state;
endpackage

// File: sv/row_gap_fill_detector.sv
// Top level of the row gap fill detector: pixel tracking and span averaging.
//
// Usage:
//  Pixels enter on the input channel (i_valid / o_stall) in raster order, one
//  item per accepted edge, each with edge mean, reference mean and row end.
//  A result item (row index and inclusive column span to blank) leaves on the
//  output channel (o_valid / i_stall); it stays in the output register until
//  taken, while the next pixels are accepted.
//  Configuration registers are written over i_cfg_valid / o_cfg_ready with
//  index 0 edge tolerance, 1 reference tolerance, 2 sample count.
//  An ordinary pixel is taken without a stall. A pixel that ends a fill
//  region starts the averaging sequencer: for each of the two spans and
//  each of n samples a multiplier and one shared divider compute the
//  sample column (a 19-step restoring division, one quotient bit a cycle),
//  then the row store is read (registered) and summed; the sum is then
//  divided by n the same way. While the sequencer runs o_stall is high;
//  at its end a result item is made only if the background average is
//  below the fill average plus the reference tolerance. A span with no
//  samples to take is skipped. If the output register is still full when a
//  result is ready, the sequencer holds until the receiver takes it.
//  Reset (synchronous, active low) clears tracking state, the counters and
//  the registers to their defaults; the row store is not cleared.
module row_gap_fill_detector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_edge_mean,
    input  logic [7:0]                 i_ref_mean,
    input  logic                       i_row_end,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rgfd_pkg::RowW-1:0]  o_row_index,
    output logic [rgfd_pkg::ColW-1:0]  o_fill_start,
    output logic [rgfd_pkg::ColW-1:0]  o_fill_end,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [7:0]                 i_cfg_data
);
    import rgfd_pkg::*;

    logic signed [7:0] r_edge_tol;
    logic [7:0]        r_ref_tol;
    logic [5:0]        r_samples;

    logic [7:0] mem [MaxCols];
    logic [7:0] r_rd_data;

    logic            r_in_bg;
    logic [ColW-1:0] r_span_begin, r_span_end, r_col;
    logic            r_begin_valid;
    logic [RowW-1:0] r_row;

    t_state r_state;
    // job latched for the sequencer
    logic [ColW-1:0] r_jb, r_je, r_jc;
    logic [RowW-1:0] r_jrow;
    logic            r_pass;       // 0 background span, 1 fill span
    logic [ColW-1:0] r_from, r_to;
    logic [5:0]      r_i;
    logic [13:0]     r_sum;
    logic [7:0]      r_bg_avg;
    // shared restoring divider
    logic [18:0]     r_num;        // dividend shifting out, quotient in
    logic [6:0]      r_rem;
    logic [4:0]      r_bit;
    logic [ColW-1:0] r_rd_addr;

    logic       accept;
    logic       bg, prev;
    logic signed [9:0] thr;
    logic [ColW-1:0]   n_col;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign thr = $signed({1'b0, BgLevel}) - 10'(r_edge_tol);
    assign bg = $signed({2'b00, i_edge_mean}) >= thr;
    assign prev = (r_col == '0) ? bg : r_in_bg;
    assign n_col = r_col + 1'b1;

    // divider step
    logic [7:0] rem_sh;
    logic [7:0] dsub;
    logic [6:0] divisor;
    assign divisor = (r_state == S_DIV) ? {1'b0, r_samples} : ({1'b0, r_samples} + 7'd1);
    assign rem_sh = {r_rem, r_num[18]};
    assign dsub = rem_sh - {1'b0, divisor};

    logic [ColW-1:0] span;
    logic [ColW-1:0] job_span;
    logic [15:0]     prod;
    logic            cmp_fire;
    assign span = r_to - r_from;
    assign job_span = r_pass ? (r_jc - r_je) : (r_je - r_jb);
    assign prod = {6'd0, span} * {10'd0, r_i + 6'd1};
    assign cmp_fire = (r_state == S_CMP) && (!o_valid || !i_stall) &&
                      ({1'b0, r_bg_avg} < ({1'b0, r_num[7:0]} + {1'b0, r_ref_tol}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_tol <= '0;
            r_ref_tol <= 8'd15;
            r_samples <= 6'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                RegEdgeTol: r_edge_tol <= i_cfg_data;
                RegRefTol:  r_ref_tol <= i_cfg_data;
                RegSamples: r_samples <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) mem[r_col] <= i_ref_mean;
        r_rd_data <= mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_bg <= 1'b0;
            r_span_begin <= '0;
            r_span_end <= '0;
            r_begin_valid <= 1'b0;
            r_col <= '0;
            r_row <= '0;
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (cmp_fire) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!prev && bg && r_begin_valid) begin
                            r_jb <= r_span_begin;
                            r_je <= r_span_end;
                            r_jc <= r_col;
                            r_jrow <= r_row;
                            r_state <= S_BSET;
                            r_pass <= 1'b0;
                        end
                        r_in_bg <= bg;
                        if (i_row_end) begin
                            r_col <= '0;
                            r_span_begin <= '0;
                            r_span_end <= '0;
                            r_begin_valid <= 1'b0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= n_col;
                            if (prev && !bg) r_span_end <= r_col;
                            else if (!prev && bg) begin
                                r_span_begin <= r_col;
                                r_begin_valid <= 1'b1;
                            end
                        end
                    end
                end
                S_BSET: begin
                    // set up one span
                    r_from <= r_pass ? r_je : r_jb;
                    r_to <= r_pass ? r_jc : r_je;
                    r_sum <= '0;
                    r_rem <= '0;
                    r_bit <= '0;
                    if (r_samples == '0 || (r_pass ? (r_je > r_jc) : (r_jb > r_je))) begin
                        r_i <= 6'd0;
                        r_num <= '0;
                        if (!r_pass) begin
                            r_bg_avg <= '0;
                            r_pass <= 1'b1;
                            r_state <= S_BSET;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end else begin
                        r_i <= 6'd1;
                        r_num <= {9'd0, job_span};
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    // one quotient bit per cycle of span*i / (n+1)
                    if (!dsub[7]) r_rem <= dsub[6:0];
                    else r_rem <= rem_sh[6:0];
                    r_num <= {r_num[17:0], !dsub[7]};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 5'd18) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rd_addr <= r_from + ColW'(r_num);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_bit == 5'd19) r_bit <= 5'd20;
                    else begin
                        r_sum <= r_sum + 14'(r_rd_data);
                        r_rem <= '0;
                        r_bit <= '0;
                        if (r_i == r_samples) begin
                            r_num <= {5'd0, r_sum + 14'(r_rd_data)};
                            r_state <= S_DIV;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_num <= {3'd0, prod};
                            r_state <= S_IDX;
                        end
                    end
                end
                S_DIV: begin
                    if (!dsub[7]) r_rem <= dsub[6:0];
                    else r_rem <= rem_sh[6:0];
                    r_num <= {r_num[17:0], !dsub[7]};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 5'd18) begin
                        if (!r_pass) begin
                            r_bg_avg <= {r_num[6:0], !dsub[7]};
                            r_pass <= 1'b1;
                            r_state <= S_BSET;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    if (!o_valid || !i_stall) begin
                        if (cmp_fire) begin
                            o_row_index <= r_jrow;
                            o_fill_start <= r_jb;
                            o_fill_end <= r_je;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "row_gap_fill_detector_assert.svh"
    `RGFD_ASSERT(a_no_accept_busy, (r_state != S_IDLE) |-> !accept, "item taken while busy")
    `RGFD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_fill_start), "result lost")
    `RGFD_ASSERT_NEXT(a_cmp_leaves, r_state == S_CMP && !i_stall, r_state == S_IDLE, "sequencer stuck")
endmodule

// File: verif/tb.sv
// Testbench for the row gap fill detector: random pixel rows checked against a span predictor.
`timescale 1ns / 1ps

// Holds the predicted blank spans and checks each result item against the oldest.
class span_board;
    typedef struct packed {
        logic [rgfd_pkg::RowW-1:0] row;
        logic [rgfd_pkg::ColW-1:0] fs;
        logic [rgfd_pkg::ColW-1:0] fe;
    } t_span;

    t_span  pending[$];
    logic [7:0] ref_store [rgfd_pkg::MaxCols];
    logic   in_bg;
    int     sp_begin, sp_end, col, row;
    logic   begin_ok;
    int     edge_tol, ref_tol, n_samp;

    function new();
        in_bg = 0; sp_begin = 0; sp_end = 0; col = 0; row = 0; begin_ok = 0;
        edge_tol = 0; ref_tol = 15; n_samp = 4;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
        case (idx)
            rgfd_pkg::RegEdgeTol: edge_tol = $signed(val);
            rgfd_pkg::RegRefTol:  ref_tol = val;
            rgfd_pkg::RegSamples: n_samp = val[5:0];
            default: ;
        endcase
    endfunction

    function int mean_of(int from, int upto);
        int acc;
        acc = 0;
        if (n_samp == 0 || from > upto) return 0;
        for (int i = 1; i <= n_samp; i++)
            acc += ref_store[(from + ((upto - from) * i) / (n_samp + 1)) % rgfd_pkg::MaxCols];
        return acc / n_samp;
    endfunction

    // Note one accepted pixel and queue any span it closes.
    function void note_pixel(logic [7:0] em, logic [7:0] rm, logic last);
        logic bg, prv;
        t_span s;
        bg = int'(em) >= 128 - edge_tol;
        prv = (col == 0) ? bg : in_bg;
        ref_store[col] = rm;
        if (prv && !bg) sp_end = col;
        else if (!prv && bg) begin
            if (begin_ok && mean_of(sp_begin, sp_end) < mean_of(sp_end, col) + ref_tol) begin
                s.row = row[11:0]; s.fs = sp_begin[9:0]; s.fe = sp_end[9:0];
                pending.push_back(s);
            end
            sp_begin = col; begin_ok = 1;
        end
        in_bg = bg;
        if (last) begin
            col = 0; sp_begin = 0; sp_end = 0; begin_ok = 0;
            row = (row + 1) % rgfd_pkg::MaxRows;
        end else col = (col + 1) % rgfd_pkg::MaxCols;
    endfunction

    // Return 1 when the result item matches the oldest expectation.
    function bit check_span(t_span got, output string why);
        t_span w;
        if (pending.size() == 0) begin
            why = "result with none expected";
            return 0;
        end
        w = pending.pop_front();
        if (got !== w) begin
            $sformat(why, "got row %0d %0d..%0d, want row %0d %0d..%0d",
                     got.row, got.fs, got.fe, w.row, w.fs, w.fe);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb;
    import rgfd_pkg::*;

    logic            i_clk, i_rst_n;
    logic            i_valid, i_stall, i_row_end;
    logic            o_stall, o_valid, o_cfg_ready;
    logic [7:0]      i_edge_mean, i_ref_mean, i_cfg_data;
    logic [1:0]      i_cfg_index;
    logic            i_cfg_valid;
    logic [RowW-1:0] o_row_index;
    logic [ColW-1:0] o_fill_start, o_fill_end;

    span_board board;
    int        n_errors = 0;
    longint    n_cycles = 0;
    bit        sink_on = 0;
    int        stall_left = 0;
    // Row width used by the generator; every column read is written earlier in the same row.
    int        row_len;

    localparam longint CycleLimit = 20_000_000;
    // Longest averaging pass with 32 samples, rounded up.
    localparam int DrainCycles = 1500;

    row_gap_fill_detector uut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Cycle counter guards against a hung handshake.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CycleLimit) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("** row_gap_fill_detector: FAILED **");
            $finish;
        end
    end

    // Sample the output channel and stall at random; mostly short stalls, a few long.
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_valid && !i_stall)
            if (!board.check_span({o_row_index, o_fill_start, o_fill_end}, why)) report(why);
        if (!sink_on) i_stall <= 0;
        else if (stall_left > 0) begin
            i_stall <= 1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) < 3) begin
            i_stall <= 1;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
                          $urandom_range(0, 2);
        end else i_stall <= 0;
    end

    task automatic gap();
        int g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) g = 0;
        repeat (g) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
    endtask

    // Hold one pixel until accepted, then note it.
    task automatic send_pixel(logic [7:0] em, logic [7:0] rm, logic last, bit idle_ok);
        if (idle_ok) gap();
        i_valid <= 1; i_edge_mean <= em; i_ref_mean <= rm; i_row_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_pixel(em, rm, last);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, val);
    endtask

    // Wait for every expected span, then let any pass without result finish.
    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Background threshold in the edge mean; pick levels either side of it.
    function automatic logic [7:0] pick_edge(bit want_bg);
        int thr;
        thr = 128 - board.edge_tol;
        if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
        if (want_bg) return (thr <= 0) ? 8'($urandom_range(0, 255)) :
                            (thr > 255) ? 8'd255 : 8'($urandom_range(thr, 255));
        return (thr <= 0) ? 8'd0 : (thr > 255) ? 8'($urandom_range(0, 255)) :
               8'($urandom_range(0, thr - 1));
    endfunction

    // One row of alternating background and fill runs with random lengths.
    task automatic send_row(int len);
        bit bg;
        int run;
        logic [7:0] lvl;
        bg = 1'($urandom_range(0, 1));
        run = $urandom_range(1, 12);
        lvl = 8'($urandom_range(0, 255));
        for (int c = 0; c < len; c++) begin
            if (run == 0) begin
                bg = !bg;
                run = $urandom_range(1, 12);
                lvl = 8'($urandom_range(0, 255));
            end
            run--;
            send_pixel(pick_edge(bg), lvl ^ 8'($urandom_range(0, 15)), c == len - 1, 1);
        end
    endtask

    initial begin
        int sent;
        board = new();
        i_rst_n = 0; i_valid = 0; i_stall = 0; i_edge_mean = 0; i_ref_mean = 0;
        i_row_end = 0; i_cfg_valid = 0; i_cfg_index = RegEdgeTol; i_cfg_data = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, a fill region closing, a fill end with no start,
        // a first-column level change, and a row end. Defaults first.
        send_pixel(8'd0, 8'd255, 0, 0);       // fill at column 0
        send_pixel(8'd255, 8'd0, 0, 0);       // fill end without recorded start
        send_pixel(8'd255, 8'd0, 0, 0);
        send_pixel(8'd0, 8'd255, 0, 0);       // background ends
        send_pixel(8'd127, 8'd255, 0, 0);
        send_pixel(8'd128, 8'd0, 0, 0);       // fill end, threshold edge
        send_pixel(8'd0, 8'd0, 0, 0);
        send_pixel(8'd200, 8'd10, 1, 0);      // fill end on row end
        send_pixel(8'd255, 8'd255, 0, 0);     // new row, column 0 background
        send_pixel(8'd0, 8'd0, 0, 0);
        send_pixel(8'd255, 8'd0, 0, 0);
        send_pixel(8'd0, 8'd255, 0, 0);
        send_pixel(8'd255, 8'd128, 1, 0);
        drain();

        // Averages only read columns already written in the current row.
        sink_on = 1;
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(RegEdgeTol, 8'h80); write_reg(RegRefTol, 8'd255);
                    write_reg(RegSamples, 8'd1);
                end
                1: begin
                    write_reg(RegEdgeTol, 8'h7F); write_reg(RegRefTol, 8'd1);
                    write_reg(RegSamples, 8'd32);
                end
                default: begin
                    write_reg(RegEdgeTol, 8'($urandom_range(0, 255)));
                    write_reg(RegRefTol, 8'($urandom_range(1, 255)));
                    write_reg(RegSamples, 8'($urandom_range(1, 32)));
                end
            endcase
            i_cfg_valid <= 0;
            // One long row to exercise the column wrap in the first phase.
            if (ph == 0) begin
                send_row(MaxCols + 5);
                sent += MaxCols + 5;
            end
            while (sent < (ph + 1) * 150 + MaxCols + 5) begin
                row_len = $urandom_range(2, 40);
                send_row(row_len);
                sent += row_len;
            end
        end

        drain();
        if (n_errors == 0)
            $display("** row_gap_fill_detector: PASSED **");
        else
            $display("** row_gap_fill_detector: FAILED **");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/rgfd_pkg.sv
sv/row_gap_fill_detector.sv
verif/tb.sv
